// File: rtl/core/dtsd_pkg.sv
package dtsd_pkg;

    // Digit buffer depth and index width
    localparam int unsigned DIG_MAX = 17;
    localparam int unsigned DIG_AW  = $clog2(DIG_MAX + 1);

    // IEEE-754 double fields
    localparam logic [62:0] EXP_FIELD  = 63'h7FF0000000000000;
    localparam logic [52:0] HIDDEN_ONE = 53'h10000000000000;
    localparam logic signed [11:0] EXP_BIAS_M1 = 12'sd1074;

    // Cached power table
    localparam int unsigned TAB_LEN  = 87;
    localparam logic [6:0]  TAB_LAST = 7'(TAB_LEN - 1);
    localparam logic [16:0] LOG10_2_FX = 17'd78913;
    localparam logic [10:0] GUESS_FX   = 11'd1233;

    // Result class codes
    localparam logic [1:0] CLS_FINITE = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;
    localparam logic [1:0] CLS_NAN    = 2'd3;

    localparam logic [63:0] MANT_TAB [0:TAB_LEN-1] = '{
        64'hfa8fd5a0081c0288, 64'hbaaee17fa23ebf76, 64'h8b16fb203055ac76, 64'hcf42894a5dce35ea,
        64'h9a6bb0aa55653b2d, 64'he61acf033d1a45df, 64'hab70fe17c79ac6ca, 64'hff77b1fcbebcdc4f,
        64'hbe5691ef416bd60c, 64'h8dd01fad907ffc3c, 64'hd3515c2831559a83, 64'h9d71ac8fada6c9b5,
        64'hea9c227723ee8bcb, 64'haecc49914078536d, 64'h823c12795db6ce57, 64'hc21094364dfb5637,
        64'h9096ea6f3848984f, 64'hd77485cb25823ac7, 64'ha086cfcd97bf97f4, 64'hef340a98172aace5,
        64'hb23867fb2a35b28e, 64'h84c8d4dfd2c63f3b, 64'hc5dd44271ad3cdba, 64'h936b9fcebb25c996,
        64'hdbac6c247d62a584, 64'ha3ab66580d5fdaf6, 64'hf3e2f893dec3f126, 64'hb5b5ada8aaff80b8,
        64'h87625f056c7c4a8b, 64'hc9bcff6034c13053, 64'h964e858c91ba2655, 64'hdff9772470297ebd,
        64'ha6dfbd9fb8e5b88f, 64'hf8a95fcf88747d94, 64'hb94470938fa89bcf, 64'h8a08f0f8bf0f156b,
        64'hcdb02555653131b6, 64'h993fe2c6d07b7fac, 64'he45c10c42a2b3b06, 64'haa242499697392d3,
        64'hfd87b5f28300ca0e, 64'hbce5086492111aeb, 64'h8cbccc096f5088cc, 64'hd1b71758e219652c,
        64'h9c40000000000000, 64'he8d4a51000000000, 64'had78ebc5ac620000, 64'h813f3978f8940984,
        64'hc097ce7bc90715b3, 64'h8f7e32ce7bea5c70, 64'hd5d238a4abe98068, 64'h9f4f2726179a2245,
        64'hed63a231d4c4fb27, 64'hb0de65388cc8ada8, 64'h83c7088e1aab65db, 64'hc45d1df942711d9a,
        64'h924d692ca61be758, 64'hda01ee641a708dea, 64'ha26da3999aef774a, 64'hf209787bb47d6b85,
        64'hb454e4a179dd1877, 64'h865b86925b9bc5c2, 64'hc83553c5c8965d3d, 64'h952ab45cfa97a0b3,
        64'hde469fbd99a05fe3, 64'ha59bc234db398c25, 64'hf6c69a72a3989f5c, 64'hb7dcbf5354e9bece,
        64'h88fcf317f22241e2, 64'hcc20ce9bd35c78a5, 64'h98165af37b2153df, 64'he2a0b5dc971f303a,
        64'ha8d9d1535ce3b396, 64'hfb9b7cd9a4a7443c, 64'hbb764c4ca7a44410, 64'h8bab8eefb6409c1a,
        64'hd01fef10a657842c, 64'h9b10a4e5e9913129, 64'he7109bfba19c0c9d, 64'hac2820d9623bf429,
        64'h80444b5e7aa7cf85, 64'hbf21e44003acdd2d, 64'h8e679c2f5e44ff8f, 64'hd433179d9c8cb841,
        64'h9e19db92b4e31ba9, 64'heb96bf6ebadf77d9, 64'haf87023b9bf0ee6b
    };

    localparam logic signed [11:0] BEXP_TAB [0:TAB_LEN-1] = '{
        -12'sd1220, -12'sd1193, -12'sd1166, -12'sd1140, -12'sd1113, -12'sd1087, -12'sd1060,
        -12'sd1034, -12'sd1007, -12'sd980, -12'sd954, -12'sd927, -12'sd901, -12'sd874,
        -12'sd847, -12'sd821, -12'sd794, -12'sd768, -12'sd741, -12'sd715, -12'sd688,
        -12'sd661, -12'sd635, -12'sd608, -12'sd582, -12'sd555, -12'sd529, -12'sd502,
        -12'sd475, -12'sd449, -12'sd422, -12'sd396, -12'sd369, -12'sd343, -12'sd316,
        -12'sd289, -12'sd263, -12'sd236, -12'sd210, -12'sd183, -12'sd157, -12'sd130,
        -12'sd103, -12'sd77, -12'sd50, -12'sd24, 12'sd3, 12'sd30, 12'sd56, 12'sd83,
        12'sd109, 12'sd136, 12'sd162, 12'sd189, 12'sd216, 12'sd242, 12'sd269, 12'sd295,
        12'sd322, 12'sd348, 12'sd375, 12'sd402, 12'sd428, 12'sd455, 12'sd481, 12'sd508,
        12'sd534, 12'sd561, 12'sd588, 12'sd614, 12'sd641, 12'sd667, 12'sd694, 12'sd720,
        12'sd747, 12'sd774, 12'sd800, 12'sd827, 12'sd853, 12'sd880, 12'sd907, 12'sd933,
        12'sd960, 12'sd986, 12'sd1013, 12'sd1039, 12'sd1066
    };

    // Powers of ten by exponent plus one; zero for an index of zero
    function automatic logic [31:0] tens(input logic [3:0] i);
        logic [31:0] r;
        unique case (i)
            4'd0:    r = 32'd0;
            4'd1:    r = 32'd1;
            4'd2:    r = 32'd10;
            4'd3:    r = 32'd100;
            4'd4:    r = 32'd1000;
            4'd5:    r = 32'd10000;
            4'd6:    r = 32'd100000;
            4'd7:    r = 32'd1000000;
            4'd8:    r = 32'd10000000;
            4'd9:    r = 32'd100000000;
            4'd10:   r = 32'd1000000000;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/dtsd_mul.sv
module dtsd_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] result
);

    // One 32x32 partial product per cycle; rounded high half of the 128-bit product
    logic        busy_reg, busy_next;
    logic [2:0]  phase_reg, phase_next;
    logic [63:0] a_reg, b_reg;
    logic [63:0] prod_reg;
    logic [33:0] mid_reg, mid_next;
    logic [63:0] hi_reg, hi_next;
    logic [31:0] mx, my;

    assign mx = phase_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign my = phase_reg[1] ? b_reg[63:32] : b_reg[31:0];

    assign done   = busy_reg && (phase_reg == 3'd5);
    assign result = hi_reg + {62'd0, mid_reg[33:32]};

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 3'd0;
            mid_next   = 34'h080000000;
            hi_next    = 64'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 3'd1;
            unique case (phase_reg)
                3'd1:
                begin
                    mid_next = mid_reg + {2'b00, prod_reg[63:32]};
                end
                3'd2, 3'd3:
                begin
                    mid_next = mid_reg + {2'b00, prod_reg[31:0]};
                    hi_next  = hi_reg + {32'd0, prod_reg[63:32]};
                end
                3'd4:
                begin
                    hi_next = hi_reg + prod_reg;
                end
                3'd5:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    hi_next = hi_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        prod_reg <= {32'd0, mx} * {32'd0, my};
        mid_reg  <= mid_next;
        hi_reg   <= hi_next;
    end

endmodule

// File: rtl/core/dtsd_dig.sv
module dtsd_dig (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [3:0]  quo,
    output logic        ovf,
    output logic [31:0] rem
);

    // Four-step restoring division; a quotient of sixteen or more flags overflow
    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  step_reg;
    logic [31:0] rem_reg, den_reg;
    logic [3:0]  quo_reg;
    logic        ovf_reg;
    logic [34:0] trial;
    logic        take;

    assign trial = {3'b000, den_reg} << step_reg;
    assign take  = {3'b000, rem_reg} >= trial;

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd3;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 2'd1;
                if (step_reg == 2'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= 4'd0;
            ovf_reg <= {4'd0, num} >= {den, 4'd0};
        end
        else if (busy_reg && take)
        begin
            rem_reg           <= rem_reg - trial[31:0];
            quo_reg[step_reg] <= 1'b1;
        end
    end

endmodule

// File: rtl/core/double_to_shortest_decimal.sv
// Shortest decimal digits of an IEEE-754 double (Grisu3).
// Input channel: one beat carries a 64-bit double bit pattern (value_bits).
// Output channel: one beat per decimal digit, most significant first; is_last
// marks the final beat of an input. value = digits x 10^decimal_exponent.
// Zero, infinity and NaN give a single beat with their class code; when the
// shortest form cannot be proven a single beat with ok low is sent.
// Steps: normalize, scale (setup, index and table lookup, then three rounded
// 64x64 multiplies through one 32x32 multiplier), digit setup, then integer
// digits (four-step restoring digit divider) or fraction digits, plus weeding.
// A finite value offers its first digit beat after these steps; a special is
// offered the cycle after acceptance.
// One input is in flight at a time: in_stall stays high from acceptance until
// the last digit beat is taken. Digit beats then leave one per cycle unless the
// receiver raises out_stall, which holds the current beat unchanged.
// Reset (rst_n low, asynchronous) drops any conversion in progress and returns
// to idle with out_valid low.
module double_to_shortest_decimal
    import dtsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        value_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         digit,
    output logic               is_last,
    output logic signed [9:0]  decimal_exponent,
    output logic               negative,
    output logic [1:0]         value_class,
    output logic               ok
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_NORM  = 5'd1;
    localparam logic [4:0] S_PREP  = 5'd2;
    localparam logic [4:0] S_IDX   = 5'd3;
    localparam logic [4:0] S_MGO   = 5'd4;
    localparam logic [4:0] S_MWAIT = 5'd5;
    localparam logic [4:0] S_DG0   = 5'd6;
    localparam logic [4:0] S_DG1   = 5'd7;
    localparam logic [4:0] S_DG2   = 5'd8;
    localparam logic [4:0] S_INT   = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_REST  = 5'd11;
    localparam logic [4:0] S_FRA   = 5'd12;
    localparam logic [4:0] S_FRB   = 5'd13;
    localparam logic [4:0] S_WSET  = 5'd14;
    localparam logic [4:0] S_WLOOP = 5'd15;
    localparam logic [4:0] S_WCHK  = 5'd16;
    localparam logic [4:0] S_WFIN  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;
    localparam logic [4:0] S_TAB   = 5'd19;

    function automatic logic [63:0] times10(input logic [63:0] a);
        return (a << 3) + (a << 1);
    endfunction

    // Control registers
    logic [4:0]        state_reg, state_next;
    logic [DIG_AW-1:0] n_reg, n_next;
    logic [DIG_AW-1:0] oidx_reg, oidx_next;
    logic [1:0]        sel_reg, sel_next;

    // Datapath registers
    logic [52:0]        vm_reg, vm_next;
    logic signed [11:0] ve_reg, ve_next;
    logic               lowc_reg, lowc_next;
    logic [63:0]        nm_reg, nm_next;
    logic [5:0]         lz_reg, lz_next;
    logic [63:0]        wm_reg, wm_next, pm_reg, pm_next, mm_reg, mm_next;
    logic signed [12:0] we_reg, we_next;
    logic signed [27:0] prod_reg, prod_next;
    logic               xz_reg, xz_next;
    logic [6:0]         idx_reg, idx_next;
    logic [63:0]        th_reg, th_next, delta_reg, delta_next, wpw_reg, wpw_next;
    logic [5:0]         sh_reg, sh_next;
    logic [31:0]        p1_reg, p1_next, div_reg, div_next;
    logic [63:0]        p2_reg, p2_next;
    logic [3:0]         guess_reg, guess_next;
    logic signed [7:0]  kappa_reg, kappa_next;
    logic [63:0]        ulp_reg, ulp_next, rest_reg, rest_next, tk_reg, tk_next;
    logic [63:0]        up_reg, up_next, down_reg, down_next;
    logic [63:0]        rt_reg, rt_next, dr_reg, dr_next;
    logic [3:0]         last_reg, last_next;
    logic               single_reg, single_next, okf_reg, okf_next, neg_reg, neg_next;
    logic [1:0]         cls_reg, cls_next;
    logic [9:0]         dexp_reg, dexp_next;
    logic [3:0]         dig_reg [0:DIG_MAX-1];
    logic               dig_we;
    logic [3:0]         dig_wdata;

    // Shared units
    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_res;
    logic        div_start, div_done, div_ovf;
    logic [3:0]  div_quo;
    logic [31:0] div_rem;

    // Combinational helpers
    logic [62:0]        mag;
    logic [10:0]        bexp;
    logic [11:0]        x_full;
    logic signed [11:0] x_s;
    logic signed [9:0]  kq;
    logic signed [11:0] kk, tt;
    logic [8:0]         tq;
    logic [9:0]         idx_w;
    logic signed [11:0] ce, mk;
    logic signed [13:0] e_full, sh_full;
    logic [63:0]        mask;
    logic [6:0]         g7;
    logic [17:0]        gp;
    logic [4:0]         g5;
    logic [31:0]        tg;
    logic [63:0]        rest_w, p2_sh, p2m;
    logic signed [11:0] dexp_w, dexp_f;
    logic               wcond, wfail, wok;

    assign mag  = value_bits[62:0];
    assign bexp = value_bits[62:52];
    assign ce   = BEXP_TAB[idx_reg];
    assign mk   = -12'sd348 + $signed({2'b00, idx_reg, 3'b000});
    assign mask = (64'd1 << sh_reg) - 64'd1;

    assign mul_start = (state_reg == S_MGO);
    assign mul_a     = (sel_reg == 2'd0) ? wm_reg : ((sel_reg == 2'd1) ? mm_reg : pm_reg);
    assign div_start = (state_reg == S_INT) && (kappa_reg != 8'sd0);

    dtsd_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (MANT_TAB[idx_reg]),
        .done   (mul_done),
        .result (mul_res)
    );

    dtsd_dig u_dig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p1_reg),
        .den   (div_reg),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf),
        .rem   (div_rem)
    );

    always_comb
    begin
        // index of the cached power: ceil(x*log10(2)) with log10(2) scaled by 2^18
        x_full = 12'($signed(-13'sd61 - we_reg));
        x_s    = $signed(x_full);
        kq     = prod_reg[27:18];
        kk     = xz_reg ? 12'sd0 : ($signed({{2{kq[9]}}, kq}) + 12'sd1);
        tt     = kk + 12'sd347;
        tq     = tt[11] ? 9'd0 : tt[11:3];
        idx_w  = {1'b0, tq} + 10'd1;

        e_full  = $signed({we_reg[12], we_reg}) + $signed({{2{ce[11]}}, ce}) + 14'sd64;
        sh_full = -e_full;

        g7 = 7'd65 - {1'b0, sh_reg};
        gp = {11'd0, g7} * {7'd0, GUESS_FX};
        g5 = 5'(gp[17:12]) + 5'd1;
        tg = tens(guess_reg);

        rest_w = ({32'd0, p1_reg} << sh_reg) + p2_reg;
        p2_sh  = p2_reg >> sh_reg;
        p2m    = p2_reg & mask;
        dexp_w = $signed({{4{kappa_reg[7]}}, kappa_reg}) - mk;
        dexp_f = dexp_w - 12'sd1;

        wcond = (rest_reg < up_reg) && (dr_reg >= tk_reg)
                && ((rt_reg < up_reg) || ((up_reg - rest_reg) >= (rt_reg - up_reg)));
        wfail = (rest_reg < down_reg) && (dr_reg >= tk_reg)
                && ((rt_reg < down_reg) || ((down_reg - rest_reg) > (rt_reg - down_reg)));
        wok   = ((ulp_reg << 1) <= rest_reg) && (rest_reg <= (delta_reg - (ulp_reg << 2)));
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        oidx_next   = oidx_reg;
        sel_next    = sel_reg;
        vm_next     = vm_reg;
        ve_next     = ve_reg;
        lowc_next   = lowc_reg;
        nm_next     = nm_reg;
        lz_next     = lz_reg;
        wm_next     = wm_reg;
        pm_next     = pm_reg;
        mm_next     = mm_reg;
        we_next     = we_reg;
        prod_next   = prod_reg;
        xz_next     = xz_reg;
        idx_next    = idx_reg;
        th_next     = th_reg;
        delta_next  = delta_reg;
        wpw_next    = wpw_reg;
        sh_next     = sh_reg;
        p1_next     = p1_reg;
        div_next    = div_reg;
        p2_next     = p2_reg;
        guess_next  = guess_reg;
        kappa_next  = kappa_reg;
        ulp_next    = ulp_reg;
        rest_next   = rest_reg;
        tk_next     = tk_reg;
        up_next     = up_reg;
        down_next   = down_reg;
        rt_next     = rt_reg;
        dr_next     = dr_reg;
        last_next   = last_reg;
        single_next = single_reg;
        okf_next    = okf_reg;
        neg_next    = neg_reg;
        cls_next    = cls_reg;
        dexp_next   = dexp_reg;
        dig_we      = 1'b0;
        dig_wdata   = div_quo;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next    = value_bits[63];
                    single_next = 1'b1;
                    okf_next    = 1'b1;
                    n_next      = '0;
                    oidx_next   = '0;
                    vm_next     = (bexp == 11'd0) ? {1'b0, mag[51:0]} : (HIDDEN_ONE | {1'b0, mag[51:0]});
                    ve_next     = (bexp == 11'd0) ? -EXP_BIAS_M1
                                                  : ($signed({1'b0, bexp}) - EXP_BIAS_M1 - 12'sd1);
                    lowc_next   = (mag[51:0] == 52'd0) && (bexp > 11'd1);
                    nm_next     = (bexp == 11'd0) ? {12'd0, mag[51:0]}
                                                  : {11'd0, HIDDEN_ONE | {1'b0, mag[51:0]}};
                    lz_next     = 6'd0;
                    priority if (mag > EXP_FIELD)
                    begin
                        cls_next   = CLS_NAN;
                        state_next = S_OUT;
                    end
                    else if (mag == 63'd0)
                    begin
                        cls_next   = CLS_ZERO;
                        state_next = S_OUT;
                    end
                    else if (mag == EXP_FIELD)
                    begin
                        cls_next   = CLS_INF;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cls_next   = CLS_FINITE;
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                // coarse steps of ten, then single steps
                priority if (nm_reg[63:54] == 10'd0)
                begin
                    nm_next = nm_reg << 10;
                    lz_next = lz_reg + 6'd10;
                end
                else if (!nm_reg[63])
                begin
                    nm_next = nm_reg << 1;
                    lz_next = lz_reg + 6'd1;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                wm_next = nm_reg;
                pm_next = nm_reg | (64'd1 << (lz_reg - 6'd1));
                mm_next = lowc_reg ? ((({11'd0, vm_reg} << 2) - 64'd1) << (lz_reg - 6'd2))
                                   : ((({11'd0, vm_reg} << 1) - 64'd1) << (lz_reg - 6'd1));
                we_next = $signed({ve_reg[11], ve_reg}) - $signed({7'd0, lz_reg});
                state_next = S_IDX;
            end
            S_IDX:
            begin
                prod_next  = 28'($signed({{16{x_s[11]}}, x_s}) * $signed({11'd0, LOG10_2_FX}));
                xz_next    = (x_s == 12'sd0);
                sel_next   = 2'd0;
                state_next = S_TAB;
            end
            S_TAB:
            begin
                // land the table index before the first multiply starts
                idx_next   = (idx_w > {3'd0, TAB_LAST}) ? TAB_LAST : idx_w[6:0];
                state_next = S_MGO;
            end
            S_MGO:
            begin
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    unique case (sel_reg)
                        2'd0:    wm_next = mul_res;
                        2'd1:    mm_next = mul_res;
                        default: pm_next = mul_res;
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = S_DG0;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_MGO;
                    end
                end
            end
            S_DG0:
            begin
                th_next    = pm_reg + 64'd1;
                delta_next = pm_reg - mm_reg + 64'd2;
                wpw_next   = pm_reg + 64'd1 - wm_reg;
                sh_next    = sh_full[5:0];
                if ((sh_full < 14'sd1) || (sh_full > 14'sd63))
                begin
                    single_next = 1'b1;
                    okf_next    = 1'b0;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_DG1;
                end
            end
            S_DG1:
            begin
                p1_next    = 32'(th_reg >> sh_reg);
                p2_next    = th_reg & mask;
                guess_next = (g5 > 5'd10) ? 4'd10 : g5[3:0];
                state_next = S_DG2;
            end
            S_DG2:
            begin
                if (p1_reg < tg)
                begin
                    kappa_next = $signed({4'd0, guess_reg - 4'd1});
                    div_next   = tens(guess_reg - 4'd1);
                end
                else
                begin
                    kappa_next = $signed({4'd0, guess_reg});
                    div_next   = tg;
                end
                state_next = S_INT;
            end
            S_INT:
            begin
                if (kappa_reg == 8'sd0)
                begin
                    ulp_next   = 64'd1;
                    state_next = S_FRA;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_ovf || (div_quo > 4'd9) || (n_reg >= DIG_AW'(DIG_MAX)))
                    begin
                        single_next = 1'b1;
                        okf_next    = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        dig_we     = 1'b1;
                        dig_wdata  = div_quo;
                        last_next  = div_quo;
                        n_next     = n_reg + 1'b1;
                        p1_next    = div_rem;
                        kappa_next = kappa_reg - 8'sd1;
                        state_next = S_REST;
                    end
                end
            end
            S_REST:
            begin
                if (rest_w < delta_reg)
                begin
                    rest_next  = rest_w;
                    tk_next    = {32'd0, div_reg} << sh_reg;
                    ulp_next   = 64'd1;
                    dexp_next  = dexp_w[9:0];
                    state_next = S_WSET;
                end
                else
                begin
                    div_next   = tens(kappa_reg[3:0]);
                    state_next = S_INT;
                end
            end
            S_FRA:
            begin
                p2_next    = times10(p2_reg);
                ulp_next   = times10(ulp_reg);
                delta_next = times10(delta_reg);
                wpw_next   = times10(wpw_reg);
                state_next = S_FRB;
            end
            S_FRB:
            begin
                if (n_reg >= DIG_AW'(DIG_MAX))
                begin
                    single_next = 1'b1;
                    okf_next    = 1'b0;
                    state_next  = S_OUT;
                end
                else
                begin
                    dig_we     = 1'b1;
                    dig_wdata  = p2_sh[3:0];
                    last_next  = p2_sh[3:0];
                    n_next     = n_reg + 1'b1;
                    p2_next    = p2m;
                    kappa_next = kappa_reg - 8'sd1;
                    if (p2m < delta_reg)
                    begin
                        rest_next  = p2m;
                        tk_next    = mask + 64'd1;
                        dexp_next  = dexp_f[9:0];
                        state_next = S_WSET;
                    end
                    else
                    begin
                        state_next = S_FRA;
                    end
                end
            end
            S_WSET:
            begin
                up_next    = wpw_reg - ulp_reg;
                down_next  = wpw_reg + ulp_reg;
                rt_next    = rest_reg + tk_reg;
                dr_next    = delta_reg - rest_reg;
                state_next = S_WLOOP;
            end
            S_WLOOP:
            begin
                // walk the last digit down toward the scaled value
                if (wcond)
                begin
                    if (last_reg == 4'd0)
                    begin
                        single_next = 1'b1;
                        okf_next    = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        last_next = last_reg - 4'd1;
                        rest_next = rt_reg;
                        rt_next   = rt_reg + tk_reg;
                        dr_next   = dr_reg - tk_reg;
                    end
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (wfail)
                begin
                    single_next = 1'b1;
                    okf_next    = 1'b0;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end
            S_WFIN:
            begin
                single_next = !wok;
                okf_next    = wok;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat fields
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_OUT);
        negative  = neg_reg;
        if (single_reg)
        begin
            digit            = 4'd0;
            is_last          = 1'b1;
            decimal_exponent = 10'sd0;
            value_class      = cls_reg;
            ok               = okf_reg;
        end
        else
        begin
            is_last          = (oidx_reg == (n_reg - 1'b1));
            digit            = is_last ? last_reg : dig_reg[oidx_reg];
            decimal_exponent = $signed(dexp_reg);
            value_class      = CLS_FINITE;
            ok               = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            oidx_reg   <= '0;
            sel_reg    <= 2'd0;
            single_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            oidx_reg   <= oidx_next;
            sel_reg    <= sel_next;
            single_reg <= single_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vm_reg    <= vm_next;
        ve_reg    <= ve_next;
        lowc_reg  <= lowc_next;
        nm_reg    <= nm_next;
        lz_reg    <= lz_next;
        wm_reg    <= wm_next;
        pm_reg    <= pm_next;
        mm_reg    <= mm_next;
        we_reg    <= we_next;
        prod_reg  <= prod_next;
        xz_reg    <= xz_next;
        idx_reg   <= idx_next;
        th_reg    <= th_next;
        delta_reg <= delta_next;
        wpw_reg   <= wpw_next;
        sh_reg    <= sh_next;
        p1_reg    <= p1_next;
        div_reg   <= div_next;
        p2_reg    <= p2_next;
        guess_reg <= guess_next;
        kappa_reg <= kappa_next;
        ulp_reg   <= ulp_next;
        rest_reg  <= rest_next;
        tk_reg    <= tk_next;
        up_reg    <= up_next;
        down_reg  <= down_next;
        rt_reg    <= rt_next;
        dr_reg    <= dr_next;
        last_reg  <= last_next;
        okf_reg   <= okf_next;
        neg_reg   <= neg_next;
        cls_reg   <= cls_next;
        dexp_reg  <= dexp_next;
        if (dig_we)
        begin
            dig_reg[n_reg] <= dig_wdata;
        end
    end

    // A result beat is only offered while input is held off
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result offered while input open");

    // Special classes and give-ups are single beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((value_class != CLS_FINITE) || !ok)) |-> (is_last && (digit == 4'd0)))
        else $error("special or failed result not a single zero beat");

    // Taking the last beat ends the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && is_last) |=> (!out_valid && !in_stall))
        else $error("burst continues after last beat");

    // Finite digits are decimal
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok) |-> (digit <= 4'd9))
        else $error("digit out of decimal range");

endmodule
